// ===== hdl/stable_priority_job_queue_unit_macros.svh =====
`ifndef STABLE_PRIORITY_JOB_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_JOB_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPJQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spjq_pkg.sv =====
package spjq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 16;
  localparam int FIELD_TAG_W     = 16;
  localparam int PRIO_W          = 8;
  localparam int INFLIGHT_W      = 16;
  localparam int QCNT_W          = 5;

  typedef enum logic [1:0] {
    FUNC_DISPATCH = 2'd0,
    FUNC_TAKE     = 2'd1,
    FUNC_COMPLETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]             func;
    logic [PRIO_W-1:0]      job_priority;
    logic [FIELD_TAG_W-1:0] job_tag;
  } in_item_t;

  typedef struct packed {
    logic                   grant_valid;
    logic [FIELD_TAG_W-1:0] granted_tag;
    logic [PRIO_W-1:0]      granted_priority;
    logic [1:0]             status;
    logic                   all_done;
    logic [QCNT_W-1:0]      queued_count;
  } out_item_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic              ins;
    logic              take;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

// ===== hdl/spjq_if.sv =====
interface spjq_in_if;
  import spjq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spjq_out_if;
  import spjq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/stable_priority_job_queue_unit.sv =====
// Stable priority job queue with an in-flight job counter.
// in_job carries one word per operation: dispatch (store job_tag with
// job_priority, count it in flight), take (hand out the highest-priority
// waiting job, earliest dispatched first among equals) or complete (lower the
// in-flight count). Each accepted word gives exactly one result word on
// out_res with the grant, a status code, the all-done flag and the number of
// jobs still waiting.
// The queue is a row of QUEUE_DEPTH cells kept sorted; every cell looks only
// at its neighbours and the broadcast command, so each operation is applied to
// the whole row at once, and a new word may be accepted on every clock edge
// while in_job.ready is high. The result word is registered on acceptance.
// The output has a register and a skid stage: while out_res is stalled the
// block still takes one further word, then drops in_job.ready until the
// receiver drains a result. Results are never lost or reordered.
// Reset (synchronous, rst_n low) empties every cell, clears the in-flight
// count and discards any pending result; no clearing pass is needed.
module stable_priority_job_queue_unit
  import spjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input logic          clk,
  input logic          rst_n,
  spjq_in_if.sink      in_job,
  spjq_out_if.source   out_res
);

  `include "stable_priority_job_queue_unit_macros.svh"

  localparam int TAG_W = (TAG_BITS < FIELD_TAG_W) ? TAG_BITS : FIELD_TAG_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0] c_valid;
  logic [QUEUE_DEPTH-1:0] c_after;
  logic [PRIO_W-1:0]      c_prio [QUEUE_DEPTH];
  logic [TAG_W-1:0]       c_tag  [QUEUE_DEPTH];

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [INFLIGHT_W-1:0] infl_r, infl_nxt;

  cell_cmd_t  cmd;
  logic       in_fire;
  logic       buf_ready;
  logic       full, empty;
  out_item_t  res;
  logic [TAG_W-1:0] new_tag;

  assign in_job.ready = buf_ready;
  assign in_fire      = in_job.valid && buf_ready;
  assign full         = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty        = (cnt_r == '0);
  assign new_tag      = in_job.data.job_tag[TAG_W-1:0];

  always_comb begin
    cmd.ins  = 1'b0;
    cmd.take = 1'b0;
    cmd.prio = in_job.data.job_priority;
    cnt_nxt  = cnt_r;
    infl_nxt = infl_r;
    res      = '0;
    case (func_t'(in_job.data.func))
      FUNC_DISPATCH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cmd.ins = in_fire;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (infl_r != '1) begin
            infl_nxt = infl_r + INFLIGHT_W'(1);
          end
        end
      end
      FUNC_TAKE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          cmd.take             = in_fire;
          cnt_nxt              = cnt_r - CNT_W'(1);
          res.grant_valid      = 1'b1;
          res.granted_tag      = FIELD_TAG_W'(c_tag[0]);
          res.granted_priority = c_prio[0];
        end
      end
      FUNC_COMPLETE: begin
        if (infl_r == '0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          infl_nxt = infl_r - INFLIGHT_W'(1);
        end
      end
      default: begin
      end
    endcase
    res.all_done     = (cnt_nxt == '0) && (infl_nxt == '0);
    res.queued_count = QCNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      infl_r <= '0;
    end else if (in_fire) begin
      cnt_r  <= cnt_nxt;
      infl_r <= infl_nxt;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic              lv, la, rv;
    logic [PRIO_W-1:0] lp, rp;
    logic [TAG_W-1:0]  lt, rt;

    if (g == 0) begin : g_head
      assign lv = 1'b0;
      assign la = 1'b1;
      assign lp = '0;
      assign lt = '0;
    end else begin : g_mid
      assign lv = c_valid[g-1];
      assign la = c_after[g-1];
      assign lp = c_prio[g-1];
      assign lt = c_tag[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rp = '0;
      assign rt = '0;
    end else begin : g_body
      assign rv = c_valid[g+1];
      assign rp = c_prio[g+1];
      assign rt = c_tag[g+1];
    end

    spjq_cell #(
      .TAG_W(TAG_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_tag    (new_tag),
      .left_valid (lv),
      .left_prio  (lp),
      .left_tag   (lt),
      .left_after (la),
      .right_valid(rv),
      .right_prio (rp),
      .right_tag  (rt),
      .valid      (c_valid[g]),
      .prio       (c_prio[g]),
      .tag        (c_tag[g]),
      .after      (c_after[g])
    );
  end

  spjq_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_data(res),
    .can_push (buf_ready),
    .out_valid(out_res.valid),
    .out_ready(out_res.ready),
    .out_data (out_res.data)
  );

  `SPJQ_ASSERT_NOW(a_count_matches_row, 1'b1, $countones(c_valid) == cnt_r, "count and cells disagree")
  `SPJQ_ASSERT_NOW(a_head_sorted, c_valid[QUEUE_DEPTH-1:1] != '0, c_valid[0] && (c_prio[0] >= c_prio[1] || !c_valid[1]), "head cell out of order")
  `SPJQ_ASSERT_NEXT(a_insert_grows, cmd.ins, cnt_r == $past(cnt_r) + CNT_W'(1), "insert did not grow queue")

endmodule

// ===== hdl/spjq_cell.sv =====
module spjq_cell
  import spjq_pkg::*;
#(
  parameter int TAG_W = DEF_TAG_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_cmd_t         cmd,
  input  logic [TAG_W-1:0]  new_tag,
  input  logic              left_valid,
  input  logic [PRIO_W-1:0] left_prio,
  input  logic [TAG_W-1:0]  left_tag,
  input  logic              left_after,
  input  logic              right_valid,
  input  logic [PRIO_W-1:0] right_prio,
  input  logic [TAG_W-1:0]  right_tag,
  output logic              valid,
  output logic [PRIO_W-1:0] prio,
  output logic [TAG_W-1:0]  tag,
  output logic              after
);

  logic              valid_r, valid_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;

  // A new job goes behind every waiting job of equal or higher priority.
  assign after = valid_r && (prio_r >= cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (cmd.ins && !after) begin
      if (left_after) begin
        valid_nxt = 1'b1;
        prio_nxt  = cmd.prio;
        tag_nxt   = new_tag;
      end else begin
        valid_nxt = left_valid;
        prio_nxt  = left_prio;
        tag_nxt   = left_tag;
      end
    end else if (cmd.take) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      tag_nxt   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign tag   = tag_r;

endmodule

// ===== hdl/spjq_out_buf.sv =====
module spjq_out_buf
  import spjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop      = main_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      // A word that cannot go straight to the output waits in the skid stage.
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule
